// File: design/u8bd_pkg.sv
// Shared types, constants and helpers for the UTF-8 to BMP decoder.
package u8bd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned AccW  = 20;
  localparam int unsigned CntW  = 2;

  // End-of-string status codes carried in the result's tuser field.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_TRUNCATED = 2'd2
  } stop_status_t;

  // One registered input byte.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } in_item_t;

  // Decoder output for one byte; have marks that a result transfer is due.
  typedef struct packed {
    logic             have;
    logic [UnitW-1:0] code_unit;
    logic             unit_valid;
    logic             end_of_run;
    stop_status_t     stop_status;
  } dec_result_t;

  // Amount removed from the summed sequence, by number of trailing bytes.
  function automatic logic [AccW-1:0] seq_offset(input logic [CntW-1:0] len);
    logic [AccW-1:0] off;
    case (len)
      2'd1:    off = 20'h03080;
      2'd2:    off = 20'hE2080;
      default: off = '0;
    endcase
    return off;
  endfunction

endpackage

// File: design/u8bd_in_reg.sv
// Input register stage: captures one byte and its end flag per transfer.
module u8bd_in_reg
  import u8bd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  in_item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: design/u8bd_decode.sv
// Sequence decoder: holds the open-sequence state and forms one result per byte.
module u8bd_decode
  import u8bd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  in_item_t    item,
  output dec_result_t res
);

  logic [CntW-1:0] pend_r, pend_nxt;
  logic [CntW-1:0] len_r, len_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;
  logic            halt_r, halt_nxt;

  logic [AccW-1:0]  sum;
  logic [AccW-1:0]  diff;
  logic [CntW-1:0]  pend_dec;
  logic             have_unit;
  logic [UnitW-1:0] unit;
  stop_status_t     status;

  assign sum      = acc_r + {{(AccW-ByteW){1'b0}}, item.data};
  assign diff     = sum - seq_offset(len_r);
  assign pend_dec = pend_r - 2'd1;

  always_comb begin
    pend_nxt  = pend_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    halt_nxt  = halt_r;
    have_unit = 1'b0;
    unit      = '0;
    status    = ST_OK;

    if (!halt_r) begin
      if (pend_r == '0) begin
        if (!item.data[7]) begin
          have_unit = 1'b1;
          unit      = {{(UnitW-ByteW){1'b0}}, item.data};
        end else if (item.data[7:5] == 3'b110) begin
          pend_nxt = 2'd1;
          len_nxt  = 2'd1;
          acc_nxt  = {{(AccW-ByteW-6){1'b0}}, item.data, 6'b0};
        end else if (item.data[7:4] == 4'b1110) begin
          pend_nxt = 2'd2;
          len_nxt  = 2'd2;
          acc_nxt  = {{(AccW-ByteW-6){1'b0}}, item.data, 6'b0};
        end else begin
          halt_nxt = 1'b1;
        end
      end else begin
        pend_nxt = pend_dec;
        if (pend_dec != '0) begin
          acc_nxt = {sum[AccW-7:0], 6'b0};
        end else begin
          have_unit = 1'b1;
          unit      = diff[UnitW-1:0];
          len_nxt   = '0;
          acc_nxt   = '0;
        end
      end
    end

    if (item.last) begin
      if (halt_nxt) begin
        status = ST_BAD_LEAD;
      end else if (pend_nxt != '0) begin
        status = ST_TRUNCATED;
      end
      pend_nxt = '0;
      len_nxt  = '0;
      acc_nxt  = '0;
      halt_nxt = 1'b0;
    end
  end

  assign res.have        = have_unit || item.last;
  assign res.code_unit   = unit;
  assign res.unit_valid  = have_unit;
  assign res.end_of_run  = item.last;
  assign res.stop_status = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      len_r  <= '0;
      acc_r  <= '0;
      halt_r <= 1'b0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      acc_r  <= acc_nxt;
      halt_r <= halt_nxt;
    end
  end

  // A halted string never has a sequence open.
  a_halt_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> pend_r == '0) else $error("halted with trailing bytes pending");

  // Between sequences the accumulator and length are clear.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == '0 |-> (acc_r == '0 && len_r == '0))
    else $error("stale sequence state with nothing pending");

  // Pending trailing bytes never exceed the sequence length.
  a_pend_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= len_r) else $error("pending count above sequence length");

endmodule

// File: design/u8bd_out_reg.sv
// Result register stage: holds one result until the downstream transfer.
module u8bd_out_reg
  import u8bd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  dec_result_t res,
  output logic        out_free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output dec_result_t out_res
);

  logic        valid_r;
  dec_result_t res_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire && res.have) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.have) begin
      res_r <= res;
    end
  end

endmodule

// File: design/utf8_to_bmp_decoder.sv
// Top level of the UTF-8 to 16-bit BMP code unit decoder.
// Path: a byte's transfer loads the input register, and the decoder then moves its result
// into the result register when that register can take it.
// Throughput: one byte per cycle while the output side keeps taking results; the
// single shift-add in the decoder stage sets this, with nothing iterated.
// Reset (rst_n low, synchronous) clears both stage valids and the sequence state.
module utf8_to_bmp_decoder
  import u8bd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel: one UTF-8 byte per transfer.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // last_byte
  // Result channel: zero or one result per byte.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic        out_tlast,  // end_of_run
  output logic [2:0]  out_tuser   // [0] unit_valid, [2:1] stop_status
);

  in_item_t    in_item;
  in_item_t    item;
  logic        item_valid;
  logic        out_free;
  logic        fire;
  dec_result_t res;
  dec_result_t out_res;

  assign in_item.data = in_tdata;
  assign in_item.last = in_tlast;

  // The decoder consumes the registered byte whenever the result register can
  // take a result this cycle. Bytes that produce no result still need this slot
  // so that the result order is simply the byte order.
  assign fire = item_valid && out_free;

  u8bd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  // The decoder state only moves on a fired byte, so stalls leave it intact.
  u8bd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  u8bd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.code_unit;
  assign out_tlast = out_res.end_of_run;
  assign out_tuser = {out_res.stop_status, out_res.unit_valid};

  // Every result either carries a character or closes a string.
  a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("result with neither a character nor an end flag");

  // A failing status is only reported on the end-of-string result.
  a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:1] != ST_OK) |-> out_tlast)
    else $error("non-zero status away from the end of a string");

  // A character is never reported together with a failing status.
  a_unit_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tuser[2:1] == ST_OK)
    else $error("character delivered with a failing status");

endmodule
